>>> hdl/vmi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// VM memory-operand integer unit: shared package
// Field widths, default sizes, the action codes and the action decoder.
// ----------------------------------------------------------------------------
package vmi_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned VMI_ACTION_W   = 4;
  localparam int unsigned VMI_IDX_W      = 3;
  localparam int unsigned VMI_IMM_W      = 32;
  localparam int unsigned VMI_MASK_W     = 21;
  localparam int unsigned VMI_WORD_W     = 64;
  localparam int unsigned VMI_BYTE_OFS_W = 3;

  // Default sizes of the register file and the scratchpad.
  localparam int unsigned VMI_NUM_REGS      = 8;
  localparam int unsigned VMI_SCRATCH_WORDS = 262144;

  // Action codes carried in the request.
  typedef enum logic [VMI_ACTION_W-1:0] {
    ACT_STORE     = 4'd0,
    ACT_ADD       = 4'd1,
    ACT_SUB       = 4'd2,
    ACT_MUL       = 4'd3,
    ACT_UMULHI    = 4'd4,
    ACT_SMULHI    = 4'd5,
    ACT_XOR       = 4'd6,
    ACT_LOAD_REG  = 4'd7,
    ACT_LOAD_WORD = 4'd8
  } action_e;

  // Control flags derived from an action code.
  typedef struct packed {
    logic store_like;  // writes the scratchpad, address based on dst
    logic rd_mem;      // reads the scratchpad, address based on src
    logic wr_reg;      // writes register dst
  } vmi_dec_t;

  // Action decoder. Codes without meaning touch no state.
  function automatic vmi_dec_t vmi_decode(input logic [VMI_ACTION_W-1:0] act);
    vmi_dec_t dec;
    dec = '0;
    unique case (act) inside
      ACT_STORE, ACT_LOAD_WORD: begin
        dec.store_like = 1'b1;
      end
      [ACT_ADD:ACT_XOR]: begin
        dec.rd_mem = 1'b1;
        dec.wr_reg = 1'b1;
      end
      ACT_LOAD_REG: begin
        dec.wr_reg = 1'b1;
      end
      default: begin
        dec = '0;
      end
    endcase
    return dec;
  endfunction

endpackage
`default_nettype wire

>>> hdl/vmi_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// VM memory-operand integer unit: channel interfaces
// Valid/ready channels for instruction requests and for results.
// ----------------------------------------------------------------------------
interface vmi_insn_if
  import vmi_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic [VMI_ACTION_W-1:0]     action;
  logic [VMI_IDX_W-1:0]        dst_index;
  logic [VMI_IDX_W-1:0]        src_index;
  logic signed [VMI_IMM_W-1:0] immediate;
  logic [VMI_MASK_W-1:0]       address_mask;
  logic [VMI_WORD_W-1:0]       load_value;
  logic                        last_insn;

  modport source (
    output valid, action, dst_index, src_index, immediate, address_mask,
           load_value, last_insn,
    input  ready
  );

  modport sink (
    input  valid, action, dst_index, src_index, immediate, address_mask,
           load_value, last_insn,
    output ready
  );
endinterface

interface vmi_result_if
  import vmi_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [VMI_WORD_W-1:0] dst_value;
  logic [VMI_WORD_W-1:0] memory_word;
  logic                  program_done;

  modport source (
    output valid, dst_value, memory_word, program_done,
    input  ready
  );

  modport sink (
    input  valid, dst_value, memory_word, program_done,
    output ready
  );
endinterface
`default_nettype wire

>>> hdl/vmi_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// VM memory-operand integer unit: generic RAM
// One write port and one read port, read data registered, read-first.
// ----------------------------------------------------------------------------
module vmi_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; a write at the same edge is not seen.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hdl/vm_memory_operand_integer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// VM memory-operand integer unit
// Runs one instruction per request against a register file and a scratchpad.
// ----------------------------------------------------------------------------
// Requests arrive on insn_i and each gives exactly one result on result_o,
// in order. Both channels use valid/ready.
// Pipeline: register read, address and scratchpad access (A), add/sub/xor
// and four 32x32 partial products (B), product combine (C), output register.
// Throughput is one request per cycle while result_o does not stall and a
// request reads no register written by either of the two requests ahead of
// it. Register values are passed on only from the write-back, after the
// multiply path through stages B and C, so a request that reads a register
// written by either of those two requests waits in stage A until that
// request has left stage C and written the register back.
// Reset empties the pipeline and clears the register valid bits, so every
// register reads as zero. The scratchpad is not cleared; a word must be
// written before it is read. When result_o stalls, up to four requests are
// held in the pipeline before insn_i.ready goes low.
// ----------------------------------------------------------------------------
module vm_memory_operand_integer_unit
  import vmi_pkg::*;
#(
  parameter int unsigned NUM_REGS      = VMI_NUM_REGS,
  parameter int unsigned SCRATCH_WORDS = VMI_SCRATCH_WORDS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vmi_insn_if.sink     insn_i,
  vmi_result_if.source result_o
);

  localparam int unsigned RIW = $clog2(NUM_REGS);
  localparam int unsigned SIW = $clog2(SCRATCH_WORDS);
  localparam int unsigned W   = VMI_WORD_W;
  localparam int unsigned HW  = W / 2;
  localparam int unsigned AW  = VMI_MASK_W;
  localparam int unsigned XW  = VMI_MASK_W - VMI_BYTE_OFS_W;
  localparam int unsigned CW  = XW / 3;

  // --------------------------------------------------------------------------
  // Register index reduction table (index modulo the register count).
  // --------------------------------------------------------------------------
  logic [RIW-1:0] ridx_lut [2**VMI_IDX_W];

  for (genvar gi = 0; gi < 2**VMI_IDX_W; gi++) begin : g_ridx
    localparam int unsigned RV = gi % NUM_REGS;
    assign ridx_lut[gi] = RIW'(RV);
  end

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  logic           accept;
  logic           a_free, a_adv, a_hazard;
  logic           b_free, b_adv;
  logic           c_free, c_adv;
  logic           o_free;

  logic [RIW-1:0] in_di, in_si;

  // Stage A
  logic                    a_vld_q;
  logic [VMI_ACTION_W-1:0] a_act_q;
  logic [RIW-1:0]          a_di_q, a_si_q;
  logic [AW-1:0]           a_imm_q;
  logic [AW-1:0]           a_mask_q;
  logic [W-1:0]            a_lv_q;
  logic                    a_last_q;
  vmi_dec_t                a_dec;
  logic [W-1:0]            a_d, a_s, a_base;
  logic [AW-1:0]           a_addr;
  logic [XW-1:0]           a_x;
  logic [SIW-1:0]          a_widx;

  // Register file
  logic [RIW-1:0]  rf_raddr_dst, rf_raddr_src;
  logic [W-1:0]    rf_rdata_dst, rf_rdata_src;
  logic            rf_rvld_dst_q, rf_rvld_src_q;
  logic [NUM_REGS-1:0] rf_vld_q;
  logic            rf_we;
  logic [W-1:0]    c_res;

  // Write-back forwarding register
  logic            w_vld_q;
  logic [RIW-1:0]  w_idx_q;
  logic [W-1:0]    w_val_q;

  // Scratchpad
  logic            sp_we, sp_re;
  logic [W-1:0]    sp_wdata, sp_rdata;

  // Stage B
  logic                    b_vld_q;
  logic [VMI_ACTION_W-1:0] b_act_q;
  logic [RIW-1:0]          b_di_q;
  logic                    b_wr_q, b_rd_q, b_last_q;
  logic [W-1:0]            b_d_q, b_word_q;
  logic [W-1:0]            b_word, b_alu, b_corr;
  logic [W-1:0]            b_ll, b_lh, b_hl, b_hh;

  // Stage C
  logic                    c_vld_q;
  logic [VMI_ACTION_W-1:0] c_act_q;
  logic [RIW-1:0]          c_di_q;
  logic                    c_wr_q, c_last_q;
  logic [W-1:0]            c_word_q, c_alu_q, c_corr_q;
  logic [W-1:0]            c_ll_q, c_lh_q, c_hl_q, c_hh_q;
  logic [HW+1:0]           c_mid;
  logic [W-1:0]            c_lo, c_hi;

  // Output register
  logic            o_vld_q;
  logic [W-1:0]    o_dst_q, o_word_q;
  logic            o_last_q;

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // --------------------------------------------------------------------------
  assign o_free = !o_vld_q || result_o.ready;
  assign c_adv  = c_vld_q && o_free;
  assign c_free = !c_vld_q || o_free;
  assign b_adv  = b_vld_q && c_free;
  assign b_free = !b_vld_q || c_free;

  // A request waits while a register it reads is still being computed.
  assign a_hazard = (b_vld_q && b_wr_q && (b_di_q == a_di_q || b_di_q == a_si_q)) ||
                    (c_vld_q && c_wr_q && (c_di_q == a_di_q || c_di_q == a_si_q));
  assign a_adv    = a_vld_q && !a_hazard && b_free;
  assign a_free   = !a_vld_q || a_adv;

  assign insn_i.ready = a_free;
  assign accept       = insn_i.valid && a_free;

  assign in_di = ridx_lut[insn_i.dst_index];
  assign in_si = ridx_lut[insn_i.src_index];

  // Valid bits of the pipeline stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
      w_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        a_vld_q <= 1'b1;
      end else if (a_adv) begin
        a_vld_q <= 1'b0;
      end
      if (a_adv) begin
        b_vld_q <= 1'b1;
      end else if (b_adv) begin
        b_vld_q <= 1'b0;
      end
      if (b_adv) begin
        c_vld_q <= 1'b1;
      end else if (c_adv) begin
        c_vld_q <= 1'b0;
      end
      if (c_adv) begin
        o_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        o_vld_q <= 1'b0;
      end
      w_vld_q <= rf_we;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A capture
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_act_q  <= insn_i.action;
      a_di_q   <= in_di;
      a_si_q   <= in_si;
      a_imm_q  <= insn_i.immediate[AW-1:0];
      a_mask_q <= insn_i.address_mask;
      a_lv_q   <= insn_i.load_value;
      a_last_q <= insn_i.last_insn;
    end
  end

  // --------------------------------------------------------------------------
  // Register file: two read copies, re-read every cycle for the request
  // that sits in stage A, so a stalled request sees later write-backs.
  // --------------------------------------------------------------------------
  assign rf_raddr_dst = accept ? in_di : a_di_q;
  assign rf_raddr_src = accept ? in_si : a_si_q;
  assign rf_we        = c_adv && c_wr_q;

  vmi_ram #(
    .WIDTH (W),
    .DEPTH (NUM_REGS)
  ) u_rf_dst (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (c_di_q),
    .wdata_i (c_res),
    .re_i    (1'b1),
    .raddr_i (rf_raddr_dst),
    .rdata_o (rf_rdata_dst)
  );

  vmi_ram #(
    .WIDTH (W),
    .DEPTH (NUM_REGS)
  ) u_rf_src (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (c_di_q),
    .wdata_i (c_res),
    .re_i    (1'b1),
    .raddr_i (rf_raddr_src),
    .rdata_o (rf_rdata_src)
  );

  // Written flags: a register never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (rf_we) begin
      rf_vld_q[c_di_q] <= 1'b1;
    end
  end

  // Flags sampled alongside the RAM read, and the last write-back.
  always_ff @(posedge clk_i) begin
    rf_rvld_dst_q <= rf_vld_q[rf_raddr_dst];
    rf_rvld_src_q <= rf_vld_q[rf_raddr_src];
    w_idx_q       <= c_di_q;
    w_val_q       <= c_res;
  end

  // Operands: the write at the read edge is not in the RAM output yet.
  always_comb begin
    a_d = rf_rvld_dst_q ? rf_rdata_dst : '0;
    a_s = rf_rvld_src_q ? rf_rdata_src : '0;
    if (w_vld_q && w_idx_q == a_di_q) begin
      a_d = w_val_q;
    end
    if (w_vld_q && w_idx_q == a_si_q) begin
      a_s = w_val_q;
    end
  end

  // --------------------------------------------------------------------------
  // Address forming. Only the low bits of the sum survive the mask, so the
  // sign extension of the immediate does not matter here.
  // --------------------------------------------------------------------------
  assign a_dec  = vmi_decode(a_act_q);
  assign a_base = a_dec.store_like ? a_d : a_s;
  assign a_addr = (a_base[AW-1:0] + a_imm_q) & a_mask_q;
  assign a_x    = a_addr[AW-1:VMI_BYTE_OFS_W];

  // Word index modulo the scratchpad depth.
  if (SCRATCH_WORDS == (1 << SIW)) begin : g_widx_pow2
    assign a_widx = a_x[SIW-1:0];
  end else begin : g_widx_lut
    localparam logic [SIW+1:0] ONE_W = (SIW+2)'(SCRATCH_WORDS);
    localparam logic [SIW+1:0] TWO_W = (SIW+2)'(2 * SCRATCH_WORDS);

    logic [SIW-1:0] lut_lo  [2**CW];
    logic [SIW-1:0] lut_mid [2**CW];
    logic [SIW-1:0] lut_hi  [2**CW];
    logic [SIW+1:0] part_sum;

    // Residues of each six-bit slice of the word address.
    for (genvar gj = 0; gj < 2**CW; gj++) begin : g_lut
      localparam int unsigned V_LO  = gj % SCRATCH_WORDS;
      localparam int unsigned V_MID = (gj << CW) % SCRATCH_WORDS;
      localparam int unsigned V_HI  = (gj << (2 * CW)) % SCRATCH_WORDS;
      assign lut_lo[gj]  = SIW'(V_LO);
      assign lut_mid[gj] = SIW'(V_MID);
      assign lut_hi[gj]  = SIW'(V_HI);
    end

    assign part_sum = (SIW+2)'(lut_lo[a_x[CW-1:0]]) +
                      (SIW+2)'(lut_mid[a_x[2*CW-1:CW]]) +
                      (SIW+2)'(lut_hi[a_x[3*CW-1:2*CW]]);

    // The sum of three residues stays below three times the depth.
    always_comb begin
      if (part_sum >= TWO_W) begin
        a_widx = SIW'(part_sum - TWO_W);
      end else if (part_sum >= ONE_W) begin
        a_widx = SIW'(part_sum - ONE_W);
      end else begin
        a_widx = SIW'(part_sum);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scratchpad: written or read as the request leaves stage A.
  // --------------------------------------------------------------------------
  assign sp_we    = a_adv && a_dec.store_like;
  assign sp_re    = a_adv && a_dec.rd_mem;
  assign sp_wdata = (a_act_q == ACT_STORE) ? a_s : a_lv_q;

  vmi_ram #(
    .WIDTH (W),
    .DEPTH (SCRATCH_WORDS)
  ) u_scratch (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .waddr_i (a_widx),
    .wdata_i (sp_wdata),
    .re_i    (sp_re),
    .raddr_i (a_widx),
    .rdata_o (sp_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage B capture. A register load carries its value in place of dst.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_act_q  <= a_act_q;
      b_di_q   <= a_di_q;
      b_wr_q   <= a_dec.wr_reg;
      b_rd_q   <= a_dec.rd_mem;
      b_last_q <= a_last_q;
      b_d_q    <= (a_act_q == ACT_LOAD_REG) ? a_lv_q : a_d;
      b_word_q <= a_dec.store_like ? sp_wdata : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: simple operations and the four partial products.
  // --------------------------------------------------------------------------
  assign b_word = b_rd_q ? sp_rdata : b_word_q;

  always_comb begin
    case (b_act_q)
      ACT_ADD: b_alu = b_d_q + b_word;
      ACT_SUB: b_alu = b_d_q - b_word;
      ACT_XOR: b_alu = b_d_q ^ b_word;
      default: b_alu = b_d_q;
    endcase
  end

  assign b_ll = b_d_q[HW-1:0] * b_word[HW-1:0];
  assign b_lh = b_d_q[HW-1:0] * b_word[W-1:HW];
  assign b_hl = b_d_q[W-1:HW] * b_word[HW-1:0];
  assign b_hh = b_d_q[W-1:HW] * b_word[W-1:HW];

  // Signed high half: subtract each operand where the other is negative.
  assign b_corr = (b_act_q == ACT_SMULHI) ?
                  ((b_d_q[W-1] ? b_word : '0) + (b_word[W-1] ? b_d_q : '0)) : '0;

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      c_act_q  <= b_act_q;
      c_di_q   <= b_di_q;
      c_wr_q   <= b_wr_q;
      c_last_q <= b_last_q;
      c_word_q <= b_word;
      c_alu_q  <= b_alu;
      c_corr_q <= b_corr;
      c_ll_q   <= b_ll;
      c_lh_q   <= b_lh;
      c_hl_q   <= b_hl;
      c_hh_q   <= b_hh;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: combine the partial products and pick the result.
  // --------------------------------------------------------------------------
  assign c_mid = (HW+2)'(c_ll_q[W-1:HW]) + (HW+2)'(c_lh_q[HW-1:0]) +
                 (HW+2)'(c_hl_q[HW-1:0]);
  assign c_lo  = {c_mid[HW-1:0], c_ll_q[HW-1:0]};
  assign c_hi  = c_hh_q + W'(c_lh_q[W-1:HW]) + W'(c_hl_q[W-1:HW]) +
                 W'(c_mid[HW+1:HW]) - c_corr_q;

  always_comb begin
    case (c_act_q) inside
      ACT_MUL:                c_res = c_lo;
      ACT_UMULHI, ACT_SMULHI: c_res = c_hi;
      default:                c_res = c_alu_q;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (c_adv) begin
      o_dst_q  <= c_res;
      o_word_q <= c_word_q;
      o_last_q <= c_last_q;
    end
  end

  assign result_o.valid        = o_vld_q;
  assign result_o.dst_value    = o_dst_q;
  assign result_o.memory_word  = o_word_q;
  assign result_o.program_done = o_last_q;

endmodule
`default_nettype wire
